/* rtl/mtc_pkg.sv */
package mtc_pkg;

  localparam int DataW = 32;
  localparam int AddrW = 3;

  localparam logic [0:0] REG_RATE_CODE = 1'd0;

  localparam logic [1:0] RATE_24   = 2'd0;
  localparam logic [1:0] RATE_25   = 2'd1;
  localparam logic [1:0] RATE_30DF = 2'd2;
  localparam logic [1:0] RATE_30   = 2'd3;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  localparam logic MSG_QUARTER = 1'b0;
  localparam logic MSG_FULL    = 1'b1;

  localparam logic [2:0] PIECE_FRAME_LO  = 3'd0;
  localparam logic [2:0] PIECE_FRAME_HI  = 3'd1;
  localparam logic [2:0] PIECE_SECOND_LO = 3'd2;
  localparam logic [2:0] PIECE_SECOND_HI = 3'd3;
  localparam logic [2:0] PIECE_MINUTE_LO = 3'd4;
  localparam logic [2:0] PIECE_MINUTE_HI = 3'd5;
  localparam logic [2:0] PIECE_HOUR_LO   = 3'd6;
  localparam logic [2:0] PIECE_RATE_HOUR = 3'd7;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] frame;
  } mtc_tc_t;

  typedef struct packed {
    logic       action;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [4:0] load_frame;
    logic       full_frame;
  } mtc_item_t;

  typedef struct packed {
    logic       msg_kind;
    logic [2:0] piece;
    logic [3:0] nibble;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [4:0] out_frame;
    logic [1:0] out_rate;
  } mtc_result_t;

  typedef struct packed {
    logic [2:0] piece_index;
    logic [1:0] quarter_count;
  } mtc_status_t;

  function automatic logic [4:0] nominal_rate(input logic [1:0] rate);
    logic [4:0] r;
    case (rate)
      RATE_24: r = 5'd24;
      RATE_25: r = 5'd25;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

/* rtl/mtc_in_if.sv */
interface mtc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [4:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_second;
  logic [4:0] load_frame;
  logic       full_frame;

  modport source (
    output valid, action, load_hour, load_minute, load_second, load_frame, full_frame,
    input  ready
  );
  modport sink (
    input  valid, action, load_hour, load_minute, load_second, load_frame, full_frame,
    output ready
  );
endinterface

/* rtl/mtc_out_if.sv */
interface mtc_out_if;
  logic       valid;
  logic       ready;
  logic       msg_kind;
  logic [2:0] piece;
  logic [3:0] nibble;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [4:0] out_frame;
  logic [1:0] out_rate;

  modport source (
    output valid, msg_kind, piece, nibble, out_hour, out_minute, out_second,
           out_frame, out_rate,
    input  ready
  );
  modport sink (
    input  valid, msg_kind, piece, nibble, out_hour, out_minute, out_second,
           out_frame, out_rate,
    output ready
  );
endinterface

/* rtl/midi_timecode_quarter_frame_generator.sv */
// channel  dir  payload                                            handshake
// item     in   action, load_hour/minute/second/frame, full_frame  valid/ready
// result   out  msg_kind, piece, nibble, out_hour..out_rate        valid/ready
// cfg      in   rate_code at 0x0                                   APB, pready=1
//
// One beat per cycle sustained while result is not stalled. Accepted beat
// lands in an input register; the counter update and nibble mux run from
// there into the result register, from which it leaves on the result
// handshake. Loads without full frame give no beat. A stalled result holds
// the result register, which holds an emitting beat in the input register,
// which drops item.ready. rst is synchronous; rate_code resets to 3.
module midi_timecode_quarter_frame_generator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mtc_pkg::AddrW-1:0] paddr,
  input  logic [mtc_pkg::DataW-1:0] pwdata,
  output logic [mtc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  mtc_in_if.sink                    item,
  mtc_out_if.source                 result
);
  import mtc_pkg::*;

  logic        [1:0] rate_code;
  mtc_item_t         s1;
  logic              s1_valid;
  logic              s1_emit;
  logic              s1_go;
  mtc_result_t       core_res;
  mtc_result_t       out_reg;
  logic              out_valid;
  mtc_status_t       status;

  mtc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .rate_code(rate_code)
  );

  mtc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (s1_go),
    .item     (s1),
    .rate_code(rate_code),
    .res      (core_res),
    .status   (status)
  );

  assign s1_emit    = s1_valid && (s1.action == ACTION_TICK || s1.full_frame);
  assign s1_go      = s1_valid && (!s1_emit || !out_valid || result.ready);
  assign item.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1.action      <= item.action;
      s1.load_hour   <= item.load_hour;
      s1.load_minute <= item.load_minute;
      s1.load_second <= item.load_second;
      s1.load_frame  <= item.load_frame;
      s1.full_frame  <= item.full_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_reg <= core_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.msg_kind   = out_reg.msg_kind;
  assign result.piece      = out_reg.piece;
  assign result.nibble     = out_reg.nibble;
  assign result.out_hour   = out_reg.out_hour;
  assign result.out_minute = out_reg.out_minute;
  assign result.out_second = out_reg.out_second;
  assign result.out_frame  = out_reg.out_frame;
  assign result.out_rate   = out_reg.out_rate;

  a_piece_quarter_lock: assert property (@(posedge clk) disable iff (rst)
    status.piece_index[1:0] == status.quarter_count)
    else $error("piece index and quarter count out of step");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> s1_valid)
    else $error("accepted beat not held in input register");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_emit |=> out_valid)
    else $error("emitted result not in result register");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.msg_kind == MSG_FULL |-> out_reg.piece == 3'd0 &&
    out_reg.nibble == 4'd0)
    else $error("full-frame beat carries quarter-frame data");
endmodule

/* rtl/mtc_cfg.sv */
module mtc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mtc_pkg::AddrW-1:0] paddr,
  input  logic [mtc_pkg::DataW-1:0] pwdata,
  output logic [mtc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output logic [1:0]                rate_code
);
  import mtc_pkg::*;

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[AddrW-1:2] == REG_RATE_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_code <= RATE_30;
    end else if (psel && penable && pwrite && pready && hit) begin
      rate_code <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[1:0] = rate_code;
    end
  end
endmodule

/* rtl/mtc_advance.sv */
module mtc_advance (
  input  mtc_pkg::mtc_tc_t tc,
  input  logic [1:0]       rate_code,
  output mtc_pkg::mtc_tc_t tc_next
);
  import mtc_pkg::*;

  logic [5:0] f_inc;
  logic [6:0] s_inc;
  logic [6:0] m_inc;
  logic [5:0] h_inc;
  logic       ten_min;

  function automatic logic mult10(input logic [5:0] m);
    return (m == 6'd0) || (m == 6'd10) || (m == 6'd20) || (m == 6'd30) ||
           (m == 6'd40) || (m == 6'd50) || (m == 6'd60);
  endfunction

  assign f_inc = {1'b0, tc.frame} + 6'd1;
  assign s_inc = {1'b0, tc.second} + 7'd1;
  assign m_inc = {1'b0, tc.minute} + 7'd1;
  assign h_inc = {1'b0, tc.hour} + 6'd1;

  always_comb begin
    tc_next = tc;
    if (f_inc >= {1'b0, nominal_rate(rate_code)}) begin
      tc_next.frame = 5'd0;
      if (s_inc >= 7'd60) begin
        tc_next.second = 6'(s_inc - 7'd60);
        if (m_inc >= 7'd60) begin
          tc_next.minute = 6'(m_inc - 7'd60);
          if (h_inc >= 6'd24) begin
            tc_next.hour = 5'(h_inc - 6'd24);
          end else begin
            tc_next.hour = h_inc[4:0];
          end
        end else begin
          tc_next.minute = m_inc[5:0];
        end
      end else begin
        tc_next.second = s_inc[5:0];
      end
    end else begin
      tc_next.frame = f_inc[4:0];
    end
    ten_min = mult10(tc_next.minute);
    if (rate_code == RATE_30DF && tc_next.second == 6'd0 && !ten_min &&
        tc_next.frame == 5'd0) begin
      tc_next.frame = 5'd2;
    end
  end
endmodule

/* rtl/mtc_core.sv */
module mtc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  mtc_pkg::mtc_item_t   item,
  input  logic [1:0]           rate_code,
  output mtc_pkg::mtc_result_t res,
  output mtc_pkg::mtc_status_t status
);
  import mtc_pkg::*;

  mtc_tc_t    tc;
  mtc_tc_t    tc_adv;
  logic [2:0] piece_index;
  logic [1:0] quarter_count;
  logic [3:0] nib;

  mtc_advance u_adv (
    .tc       (tc),
    .rate_code(rate_code),
    .tc_next  (tc_adv)
  );

  always_comb begin
    case (piece_index)
      PIECE_FRAME_LO:  nib = tc.frame[3:0];
      PIECE_FRAME_HI:  nib = {3'b000, tc.frame[4]};
      PIECE_SECOND_LO: nib = tc.second[3:0];
      PIECE_SECOND_HI: nib = {2'b00, tc.second[5:4]};
      PIECE_MINUTE_LO: nib = tc.minute[3:0];
      PIECE_MINUTE_HI: nib = {2'b00, tc.minute[5:4]};
      PIECE_HOUR_LO:   nib = tc.hour[3:0];
      default:         nib = {1'b0, rate_code, tc.hour[4]};
    endcase
  end

  always_comb begin
    res = '0;
    if (item.action == ACTION_TICK) begin
      res.msg_kind = MSG_QUARTER;
      res.piece    = piece_index;
      res.nibble   = nib;
    end else begin
      res.msg_kind   = MSG_FULL;
      res.out_hour   = item.load_hour;
      res.out_minute = item.load_minute;
      res.out_second = item.load_second;
      res.out_frame  = item.load_frame;
      res.out_rate   = rate_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tc            <= '0;
      piece_index   <= '0;
      quarter_count <= '0;
    end else if (fire) begin
      if (item.action == ACTION_TICK) begin
        piece_index   <= piece_index + 3'd1;
        quarter_count <= quarter_count + 2'd1;
        if (quarter_count == 2'd3) begin
          tc <= tc_adv;
        end
      end else begin
        tc.hour       <= item.load_hour;
        tc.minute     <= item.load_minute;
        tc.second     <= item.load_second;
        tc.frame      <= item.load_frame;
        piece_index   <= '0;
        quarter_count <= '0;
      end
    end
  end

  assign status.piece_index   = piece_index;
  assign status.quarter_count = quarter_count;
endmodule

/* tb/sv/tb_midi_timecode_quarter_frame_generator.sv */
`timescale 1ns / 1ps

module tb_midi_timecode_quarter_frame_generator;
  import mtc_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  mtc_in_if  item_bus ();
  mtc_out_if result_bus ();

  logic       item_valid = 1'b0;
  mtc_item_t  item_beat = '0;
  logic       result_ready = 1'b0;

  assign item_bus.valid       = item_valid;
  assign item_bus.action      = item_beat.action;
  assign item_bus.load_hour   = item_beat.load_hour;
  assign item_bus.load_minute = item_beat.load_minute;
  assign item_bus.load_second = item_beat.load_second;
  assign item_bus.load_frame  = item_beat.load_frame;
  assign item_bus.full_frame  = item_beat.full_frame;
  assign result_bus.ready     = result_ready;

  midi_timecode_quarter_frame_generator dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_bus),
    .result  (result_bus)
  );

  always #5 clk = ~clk;

  // timecode predictor state
  logic [1:0] rate_sel = RATE_30;
  logic [4:0] tc_hour = '0;
  logic [5:0] tc_minute = '0;
  logic [5:0] tc_second = '0;
  logic [4:0] tc_frame = '0;
  logic [2:0] tc_piece = '0;
  logic [1:0] tc_quarter = '0;

  mtc_item_t   pending_items[$];
  mtc_result_t expected_msgs[$];

  int  queued_items = 0;
  int  accepted_items = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  item_fire = 1'b0;
  bit  result_fire = 1'b0;
  bit  calm = 1'b0;

  function automatic int frame_limit(input logic [1:0] rate);
    case (rate)
      RATE_24: return 24;
      RATE_25: return 25;
      default: return 30;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int edge_val(input int lim, input int bits);
    case ($urandom_range(0, 4))
      0: return lim - 1;
      1: return lim - 1 - $urandom_range(0, 2);
      2: return $urandom_range(0, lim - 1);
      3: return $urandom_range(0, (1 << bits) - 1);
      default: return 0;
    endcase
  endfunction

  task automatic predict_mtc(input mtc_item_t it);
    mtc_result_t m;
    int f, s, mi, h;
    m = '0;
    if (it.action == ACTION_TICK) begin
      m.msg_kind = MSG_QUARTER;
      m.piece = tc_piece;
      case (tc_piece)
        PIECE_FRAME_LO:  m.nibble = tc_frame[3:0];
        PIECE_FRAME_HI:  m.nibble = {3'b000, tc_frame[4]};
        PIECE_SECOND_LO: m.nibble = tc_second[3:0];
        PIECE_SECOND_HI: m.nibble = {2'b00, tc_second[5:4]};
        PIECE_MINUTE_LO: m.nibble = tc_minute[3:0];
        PIECE_MINUTE_HI: m.nibble = {2'b00, tc_minute[5:4]};
        PIECE_HOUR_LO:   m.nibble = tc_hour[3:0];
        default:         m.nibble = {1'b0, rate_sel, tc_hour[4]};
      endcase
      expected_msgs.push_back(m);
      tc_piece = tc_piece + 3'd1;
      tc_quarter = tc_quarter + 2'd1;
      if (tc_quarter == 2'd0) begin
        f = tc_frame + 1;
        s = tc_second;
        mi = tc_minute;
        h = tc_hour;
        if (f >= frame_limit(rate_sel)) begin
          f = 0;
          s++;
          if (s >= 60) begin
            s = s % 60;
            mi++;
            if (mi >= 60) begin
              mi = mi % 60;
              h++;
              if (h >= 24) h = h % 24;
            end
          end
        end
        // drop-frame skip at non-tenth minutes
        if (rate_sel == RATE_30DF && s == 0 && (mi % 10) != 0 && f == 0) f = 2;
        tc_frame = 5'(f);
        tc_second = 6'(s);
        tc_minute = 6'(mi);
        tc_hour = 5'(h);
      end
    end else begin
      tc_hour = it.load_hour;
      tc_minute = it.load_minute;
      tc_second = it.load_second;
      tc_frame = it.load_frame;
      tc_piece = '0;
      tc_quarter = '0;
      if (it.full_frame) begin
        m.msg_kind = MSG_FULL;
        m.out_hour = it.load_hour;
        m.out_minute = it.load_minute;
        m.out_second = it.load_second;
        m.out_frame = it.load_frame;
        m.out_rate = rate_sel;
        expected_msgs.push_back(m);
      end
    end
  endtask

  function automatic void check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endfunction

  task automatic push_tick();
    mtc_item_t it;
    it = mtc_item_t'($urandom());
    it.action = ACTION_TICK;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic push_load(input int h, input int m, input int s, input int f, input bit ff);
    mtc_item_t it;
    it.action = ACTION_LOAD;
    it.load_hour = 5'(h);
    it.load_minute = 6'(m);
    it.load_second = 6'(s);
    it.load_frame = 5'(f);
    it.full_frame = ff;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic cfg_write(input logic [1:0] rate);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({REG_RATE_CODE, 2'b00});
    pwdata <= DataW'(rate);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rate_sel = rate;
    @(posedge clk);
    #1;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (accepted_items != queued_items || expected_msgs.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    #1;
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (gap_left > 0) begin
        item_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() != 0) begin
        item_beat <= pending_items.pop_front();
        item_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // accept, predict, check, watchdog
  always @(posedge clk) begin
    mtc_result_t want;
    item_fire = !rst && item_bus.valid && item_bus.ready;
    result_fire = !rst && result_bus.valid && result_bus.ready;
    if (item_fire) begin
      predict_mtc(item_beat);
      accepted_items++;
    end
    if (result_fire) begin
      if (expected_msgs.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_msgs.pop_front();
        check_field("msg_kind", want.msg_kind, result_bus.msg_kind);
        check_field("piece", want.piece, result_bus.piece);
        check_field("nibble", want.nibble, result_bus.nibble);
        check_field("out_hour", want.out_hour, result_bus.out_hour);
        check_field("out_minute", want.out_minute, result_bus.out_minute);
        check_field("out_second", want.out_second, result_bus.out_second);
        check_field("out_frame", want.out_frame, result_bus.out_frame);
        check_field("out_rate", want.out_rate, result_bus.out_rate);
      end
    end
    if (item_fire || result_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [1:0] phase_rates[6];
    logic [1:0] rate_now;
    int n, r, burst, mi;
    phase_rates = '{RATE_24, RATE_30DF, RATE_25, RATE_30, RATE_30DF, RATE_30};
    phase_rates[5] = 2'($urandom_range(0, 3));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // reset rate: walk all eight pieces, then full-scale load and wrap
    repeat (8) push_tick();
    push_load(23, 59, 59, 29, 1'b1);
    repeat (8) push_tick();
    wait_drained();

    // drop frame: skip at minute 2, load not corrected, out-of-range load
    cfg_write(RATE_30DF);
    push_load(0, 1, 59, 29, 1'b0);
    repeat (4) push_tick();
    push_load(0, 1, 0, 0, 1'b1);
    push_tick();
    push_load(31, 63, 63, 31, 1'b1);
    repeat (4) push_tick();
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      rate_now = phase_rates[phase];
      calm = (phase == 3);
      cfg_write(rate_now);
      n = 0;
      while (n < 190) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          burst = $urandom_range(1, 40);
          repeat (burst) push_tick();
          n += burst;
        end else if (r < 88) begin
          mi = edge_val(60, 6);
          if ($urandom_range(0, 3) == 0) mi = 10 * $urandom_range(0, 5) + 9;
          push_load(edge_val(24, 5), mi, edge_val(60, 6),
                    edge_val(frame_limit(rate_now), 5), 1'($urandom_range(0, 1)));
          n++;
        end else begin
          push_load($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 31), 1'($urandom_range(0, 1)));
          n++;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
